// ----- hw/rtl/nll_pkg.sv -----
`default_nettype none

package nll_pkg;

   localparam int LengthBitsDefault = 8;

   // character classes
   localparam logic [3:0] CLS_ZERO   = 4'd0;
   localparam logic [3:0] CLS_OCT    = 4'd1;  // 1 to 7
   localparam logic [3:0] CLS_DIG89  = 4'd2;
   localparam logic [3:0] CLS_HEXLET = 4'd3;  // A-F, a-f
   localparam logic [3:0] CLS_X      = 4'd4;
   localparam logic [3:0] CLS_DOT    = 4'd5;
   localparam logic [3:0] CLS_PLUS   = 4'd6;
   localparam logic [3:0] CLS_MINUS  = 4'd7;
   localparam logic [3:0] CLS_OTHER  = 4'd8;

   // scanner phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_SIGN = 3'd1;
   localparam logic [2:0] PH_ZERO = 3'd2;
   localparam logic [2:0] PH_HEX  = 3'd3;
   localparam logic [2:0] PH_OCT  = 3'd4;
   localparam logic [2:0] PH_DEC  = 3'd5;
   localparam logic [2:0] PH_FLT  = 3'd6;

   // literal kinds
   localparam logic [1:0] KIND_DEC = 2'd0;
   localparam logic [1:0] KIND_OCT = 2'd1;
   localparam logic [1:0] KIND_HEX = 2'd2;
   localparam logic [1:0] KIND_FLT = 2'd3;

   // sign codes
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_MINUS = 2'd2;

   typedef struct packed {
      logic       fire;
      logic [1:0] kind;
      logic [1:0] sign_seen;
      logic [7:0] length;
      logic       error;
   } nll_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/nll_classify.sv -----
`default_nettype none

module nll_classify
   import nll_pkg::*;
(
   input  wire logic [7:0] char_code,
   output logic      [3:0] char_class
);

   always_comb begin
      if (char_code == 8'h30) begin
         char_class = CLS_ZERO;
      end else if (char_code >= 8'h31 && char_code <= 8'h37) begin
         char_class = CLS_OCT;
      end else if (char_code == 8'h38 || char_code == 8'h39) begin
         char_class = CLS_DIG89;
      end else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                   (char_code >= 8'h61 && char_code <= 8'h66)) begin
         char_class = CLS_HEXLET;
      end else if (char_code == 8'h78 || char_code == 8'h58) begin
         char_class = CLS_X;
      end else if (char_code == 8'h2E) begin
         char_class = CLS_DOT;
      end else if (char_code == 8'h2B) begin
         char_class = CLS_PLUS;
      end else if (char_code == 8'h2D) begin
         char_class = CLS_MINUS;
      end else begin
         char_class = CLS_OTHER;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/nll_step.sv -----
`default_nettype none

module nll_step
   import nll_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic [3:0]             char_class,
   input  wire logic                   start_req,
   input  wire logic [2:0]             phase,
   input  wire logic [LENGTH_BITS-1:0] count,
   input  wire logic [1:0]             sign_held,
   output logic      [2:0]             phase_next,
   output logic      [LENGTH_BITS-1:0] count_next,
   output logic      [1:0]             sign_next,
   output nll_rsp_type                 rsp
);

   localparam int WideBits = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;

   logic [LENGTH_BITS-1:0] count_bump;
   logic [WideBits-1:0]    count_wide;
   logic [7:0]             len_cap;
   logic                   is_dig;
   logic                   is_oct;
   logic                   is_hex;

   assign count_bump = (count == {LENGTH_BITS{1'b1}}) ? count : count + LENGTH_BITS'(1);
   assign count_wide = WideBits'(count);
   assign len_cap    = (count_wide > WideBits'(255)) ? 8'hFF : count_wide[7:0];
   assign is_oct     = (char_class == CLS_ZERO) || (char_class == CLS_OCT);
   assign is_dig     = is_oct || (char_class == CLS_DIG89);
   assign is_hex     = is_dig || (char_class == CLS_HEXLET);

   always_comb begin
      phase_next    = phase;
      count_next    = count;
      sign_next     = sign_held;
      rsp.fire      = 1'b0;
      rsp.kind      = KIND_DEC;
      rsp.sign_seen = sign_held;
      rsp.length    = len_cap;
      rsp.error     = 1'b0;
      if (start_req) begin
         // a fresh literal drops whatever was in progress
         count_next = LENGTH_BITS'(1);
         sign_next  = SIGN_NONE;
         case (char_class)
            CLS_ZERO: begin
               phase_next = PH_ZERO;
            end
            CLS_OCT, CLS_DIG89: begin
               phase_next = PH_DEC;
            end
            CLS_PLUS: begin
               phase_next = PH_SIGN;
               sign_next  = SIGN_PLUS;
            end
            CLS_MINUS: begin
               phase_next = PH_SIGN;
               sign_next  = SIGN_MINUS;
            end
            default: begin
               phase_next    = PH_IDLE;
               count_next    = '0;
               rsp.fire      = 1'b1;
               rsp.error     = 1'b1;
               rsp.sign_seen = SIGN_NONE;
               rsp.length    = 8'd0;
            end
         endcase
      end else begin
         unique case (phase)
            PH_IDLE: begin
               phase_next = PH_IDLE;
            end
            PH_SIGN: begin
               if (char_class == CLS_ZERO) begin
                  phase_next = PH_ZERO;
                  count_next = count_bump;
               end else if (is_dig) begin
                  phase_next = PH_DEC;
                  count_next = count_bump;
               end else begin
                  rsp.fire  = 1'b1;
                  rsp.error = 1'b1;
               end
            end
            PH_ZERO: begin
               if (char_class == CLS_X) begin
                  phase_next = PH_HEX;
                  count_next = count_bump;
               end else if (is_oct) begin
                  phase_next = PH_OCT;
                  count_next = count_bump;
               end else begin
                  rsp.fire = 1'b1;
                  rsp.kind = KIND_OCT;
               end
            end
            PH_HEX: begin
               if (is_hex) begin
                  count_next = count_bump;
               end else begin
                  rsp.fire = 1'b1;
                  rsp.kind = KIND_HEX;
               end
            end
            PH_OCT: begin
               if (is_oct) begin
                  count_next = count_bump;
               end else begin
                  rsp.fire = 1'b1;
                  rsp.kind = KIND_OCT;
               end
            end
            PH_DEC: begin
               if (is_dig) begin
                  count_next = count_bump;
               end else if (char_class == CLS_DOT) begin
                  phase_next = PH_FLT;
                  count_next = count_bump;
               end else begin
                  rsp.fire = 1'b1;
               end
            end
            PH_FLT: begin
               if (is_dig) begin
                  count_next = count_bump;
               end else begin
                  rsp.fire = 1'b1;
                  rsp.kind = KIND_FLT;
               end
            end
            default: begin
               phase_next = PH_IDLE;
            end
         endcase
         if (rsp.fire) begin
            phase_next = PH_IDLE;
            count_next = '0;
            sign_next  = SIGN_NONE;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/numeric_literal_lexer.sv -----
`default_nettype none

// channel   direction  fields                                   transfer
// req_      in         char_code[7:0], start_req                req_valid & req_ready
// rsp_      out        kind[1:0], sign_seen[1:0], length[7:0],  rsp_valid & rsp_ready
//                      error
//
// one character per cycle while no stalled result holds the input register; the result
// for the character that ends the literal passes the input register, then the result register
// the automaton step between those registers sets the rate: one item a cycle unless stalled
// reset is synchronous and leaves the scanner idle with both registers empty
// a stalled result holds the input register; req_ready stays high while it
// can move on or is empty

module numeric_literal_lexer
   import nll_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_start_req,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [1:0] rsp_kind,
   output logic      [1:0] rsp_sign_seen,
   output logic      [7:0] rsp_length,
   output logic            rsp_error
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff;
   logic                   in_start_ff;
   logic [2:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [1:0]             sign_ff, sign_in;
   logic                   out_valid_ff, out_valid_in;
   nll_rsp_type            out_ff;
   logic [3:0]             char_class;
   nll_rsp_type            step_rsp;
   logic                   advance;
   logic                   req_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   nll_classify u_classify (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   nll_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .char_class (char_class),
      .start_req  (in_start_ff),
      .phase      (phase_ff),
      .count      (count_ff),
      .sign_held  (sign_ff),
      .phase_next (phase_in),
      .count_next (count_in),
      .sign_next  (sign_in),
      .rsp        (step_rsp)
   );

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && step_rsp.fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         sign_ff      <= SIGN_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            sign_ff  <= sign_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff  <= req_char_code;
         in_start_ff <= req_start_req;
      end
      if (advance && step_rsp.fire) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_ff.kind;
   assign rsp_sign_seen = out_ff.sign_seen;
   assign rsp_length    = out_ff.length;
   assign rsp_error     = out_ff.error;

   // an idle scanner carries no leftover count or sign
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> count_ff == '0 && sign_ff == SIGN_NONE)
      else $error("idle scanner holds stale count or sign");

   // after a sign exactly one character has been counted
   a_sign_state: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SIGN |-> sign_ff != SIGN_NONE && count_ff == LENGTH_BITS'(1))
      else $error("sign phase without a held sign");

   // error results are decimal and at most the sign long
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_kind == KIND_DEC && rsp_length <= 8'd1)
      else $error("malformed error result");

   // a stalled result blocks the step, so state may not move
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(phase_ff) && $stable(count_ff))
      else $error("scanner advanced under a stalled result");

endmodule

`default_nettype wire

// ----- dv/lexer_tb_pkg.sv -----
package lexer_tb_pkg;

   import nll_pkg::*;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_ONE   = "1";
   localparam logic [7:0] CH_SEVEN = "7";
   localparam logic [7:0] CH_NINE  = "9";
   localparam logic [7:0] CH_UA    = "A";
   localparam logic [7:0] CH_UF    = "F";
   localparam logic [7:0] CH_LA    = "a";
   localparam logic [7:0] CH_LF    = "f";
   localparam logic [7:0] CH_LX    = "x";
   localparam logic [7:0] CH_UX    = "X";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_MINUS = "-";

   localparam int COUNT_MAX = (1 << LengthBitsDefault) - 1;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] sign_seen;
      logic [7:0] length;
      logic       error;
   } literal_type;

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   class literal_scoreboard;
      logic [2:0]  phase;
      int          count;
      logic [1:0]  sign_held;
      literal_type pending_literals[$];
      int          scanned_chars;
      int          failures;

      function new();
         phase = PH_IDLE;
         count = 0;
         sign_held = SIGN_NONE;
         scanned_chars = 0;
         failures = 0;
      endfunction

      function void advance(logic [2:0] next_phase);
         if (count < COUNT_MAX) count++;
         phase = next_phase;
      endfunction

      function void close_literal(logic [1:0] kind, int len, logic err);
         literal_type lit;
         lit.kind = kind;
         lit.sign_seen = sign_held;
         lit.length = (len > 255) ? 8'd255 : 8'(len);
         lit.error = err;
         pending_literals.push_back(lit);
         phase = PH_IDLE;
         count = 0;
         sign_held = SIGN_NONE;
      endfunction

      // one accepted character through the scanner automaton
      function void note_char(logic [7:0] c, logic start);
         if (start || phase != PH_IDLE) scanned_chars++;
         if (start) begin
            phase = PH_IDLE;
            count = 0;
            sign_held = SIGN_NONE;
            if (c == CH_ZERO) advance(PH_ZERO);
            else if (is_digit(c)) advance(PH_DEC);
            else if (c == CH_PLUS || c == CH_MINUS) begin
               sign_held = (c == CH_PLUS) ? SIGN_PLUS : SIGN_MINUS;
               advance(PH_SIGN);
            end else close_literal(KIND_DEC, 0, 1'b1);
         end else begin
            case (phase)
               PH_SIGN: begin
                  if (c == CH_ZERO) advance(PH_ZERO);
                  else if (is_digit(c)) advance(PH_DEC);
                  else close_literal(KIND_DEC, count, 1'b1);
               end
               PH_ZERO: begin
                  if (c == CH_LX || c == CH_UX) advance(PH_HEX);
                  else if (c >= CH_ZERO && c <= CH_SEVEN) advance(PH_OCT);
                  else close_literal(KIND_OCT, count, 1'b0);
               end
               PH_HEX: begin
                  if (is_digit(c) || (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF))
                     advance(PH_HEX);
                  else close_literal(KIND_HEX, count, 1'b0);
               end
               PH_OCT: begin
                  if (c >= CH_ZERO && c <= CH_SEVEN) advance(PH_OCT);
                  else close_literal(KIND_OCT, count, 1'b0);
               end
               PH_DEC: begin
                  if (is_digit(c)) advance(PH_DEC);
                  else if (c == CH_DOT) advance(PH_FLT);
                  else close_literal(KIND_DEC, count, 1'b0);
               end
               PH_FLT: begin
                  if (is_digit(c)) advance(PH_FLT);
                  else close_literal(KIND_FLT, count, 1'b0);
               end
               default: phase = PH_IDLE;
            endcase
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         failures++;
      endtask

      task check_literal(literal_type got);
         literal_type want;
         if (pending_literals.size() == 0) begin
            report_mismatch($sformatf("unexpected literal kind %0d sign %0d length %0d error %0d",
                                      got.kind, got.sign_seen, got.length, got.error));
         end else begin
            want = pending_literals.pop_front();
            if (got.kind != want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.sign_seen != want.sign_seen)
               report_mismatch($sformatf("sign %0d, expected %0d", got.sign_seen, want.sign_seen));
            if (got.length != want.length)
               report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
            if (got.error != want.error)
               report_mismatch($sformatf("error %0d, expected %0d", got.error, want.error));
         end
      endtask
   endclass

endpackage

// ----- dv/tb_top.sv -----
module tb_top;

   import nll_pkg::*;
   import lexer_tb_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_code;
   logic       req_start_req;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [1:0] rsp_sign_seen;
   logic [7:0] rsp_length;
   logic       rsp_error;

   literal_scoreboard sb = new();

   int burst_left;
   int hold_left;
   int rx_cycle;
   bit hold_request;

   numeric_literal_lexer DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_sign_seen (rsp_sign_seen),
      .rsp_length    (rsp_length),
      .rsp_error     (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #600000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic drive_char(input logic [7:0] c, input logic start);
      @(negedge clock);
      req_valid <= 1'b1;
      req_char_code <= c;
      req_start_req <= start;
      do @(posedge clock); while (!req_ready);
      sb.note_char(c, start);
   endtask

   task automatic drive_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) drive_char(s[i], i == 0);
   endtask

   // bursts of random length, now and then a long one with no gaps at all
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(5) == 0) ? 200 : $urandom_range(1, 40);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_literals.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_literal(input bit long_body);
      logic [7:0] chars[$];
      logic [7:0] c;
      int shape;
      int body_len;
      int r;
      int i;
      case ($urandom_range(2))
         1: chars.push_back(CH_PLUS);
         2: chars.push_back(CH_MINUS);
         default: ;
      endcase
      body_len = long_body ? $urandom_range(250, 300) : $urandom_range(0, 6);
      shape = long_body ? 0 : $urandom_range(5);
      case (shape)
         0, 3: begin
            chars.push_back(8'($urandom_range(CH_ONE, CH_NINE)));
            repeat (body_len) chars.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            if (shape == 3) begin
               chars.push_back(CH_DOT);
               repeat ($urandom_range(0, 5)) chars.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
         end
         1: begin
            chars.push_back(CH_ZERO);
            repeat (body_len) chars.push_back(8'($urandom_range(CH_ZERO, CH_SEVEN)));
         end
         2: begin
            chars.push_back(CH_ZERO);
            chars.push_back($urandom_range(1) ? CH_LX : CH_UX);
            repeat (body_len) begin
               r = $urandom_range(21);
               if (r < 10) c = CH_ZERO + 8'(r);
               else if (r < 16) c = CH_LA + 8'(r - 10);
               else c = CH_UA + 8'(r - 16);
               chars.push_back(c);
            end
         end
         4: chars.push_back(CH_ZERO);
         default: begin
            // broken literal: bad first character, or bad one after the sign
            do c = 8'($urandom_range(255));
            while (is_digit(c) || c == CH_PLUS || c == CH_MINUS);
            chars.push_back(c);
         end
      endcase
      case ($urandom_range(3))
         1: begin
            case ($urandom_range(5))
               0: chars.push_back(CH_DOT);
               1: chars.push_back("8");
               2: chars.push_back(CH_NUL);
               3: chars.push_back(" ");
               4: chars.push_back(";");
               default: chars.push_back(CH_LX);
            endcase
         end
         // no terminator: the next start drops the scan in progress
         2: ;
         default: chars.push_back(8'($urandom_range(255)));
      endcase
      for (i = 0; i < chars.size(); i++) begin
         pace_sender();
         drive_char(chars[i], i == 0);
      end
   endtask

   // receiver: ready pattern rotates through three modes by rx_cycle, long hold-off on request
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = 60;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cycle / 150) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(1));
            default: rsp_ready <= (rx_cycle % 5) == 0;
         endcase
      end
      rx_cycle++;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_literal(literal_type'{kind: rsp_kind, sign_seen: rsp_sign_seen,
                                        length: rsp_length, error: rsp_error});
   end

   initial begin
      int seq_no;
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_code = 8'h00;
      req_start_req = 1'b0;
      rsp_ready = 1'b0;
      burst_left = 0;
      hold_left = 0;
      rx_cycle = 0;
      hold_request = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      drive_text("5.2.");
      drive_text("-0xFag");
      drive_text("09");
      drive_text("017");
      drive_char(8'hFF, 1'b0);
      drive_text("z");
      drive_text("-q");
      drive_text("+0X");
      drive_char(CH_NUL, 1'b0);
      // start during a scan drops the first literal
      drive_text("3");
      drive_text("4,");
      drive_char("5", 1'b0);

      seq_no = 0;
      while (sb.scanned_chars < 1250) begin
         if (seq_no == 100) drain_results();
         if (seq_no == 150) begin
            // results pile up behind the stalled receiver until req_ready drops
            hold_request = 1'b1;
            repeat (16) drive_char("#", 1'b1);
         end
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               pace_sender();
               drive_char(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
         end
         send_random_literal(seq_no == 40 || $urandom_range(199) == 0);
         seq_no++;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
